FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. Simulation only; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, switched off while reset is asserted.
`define ACPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property that also holds during reset.
`define ACPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ACPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/acps_pkg.sv
`default_nettype none

package acps_pkg;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_START     = 2'd1,
    CMD_STOP      = 2'd2,
    CMD_CALIBRATE = 2'd3
  } acps_cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WAIT   = 2'd1,
    PH_CHARGE = 2'd2
  } acps_phase_e;

  localparam logic [2:0] PILOT_12V = 3'd0;
  localparam logic [2:0] PILOT_9V  = 3'd1;
  localparam logic [2:0] PILOT_6V  = 3'd2;
  localparam logic [2:0] PILOT_0V  = 3'd3;

  localparam logic [3:0] CAUSE_NORMAL   = 4'd0;
  localparam logic [3:0] CAUSE_PILOT    = 4'd1;
  localparam logic [3:0] CAUSE_SCRAM    = 4'd2;
  localparam logic [3:0] CAUSE_OVERVOLT = 4'd3;
  localparam logic [3:0] CAUSE_UNDERVOLT = 4'd4;
  localparam logic [3:0] CAUSE_OVERCUR  = 4'd5;
  localparam logic [3:0] CAUSE_UNDERCUR = 4'd6;
  localparam logic [3:0] CAUSE_METER    = 4'd7;
  localparam logic [3:0] CAUSE_PAUSES   = 4'd8;
  localparam logic [3:0] CAUSE_SUSPEND  = 4'd9;

  // Register map, index = paddr[4:2]
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_DUTY      = 3'd0;
  localparam logic [2:0] REG_OC_TICKS  = 3'd1;
  localparam logic [2:0] REG_UC_TICKS  = 3'd2;
  localparam logic [2:0] REG_SUSP      = 3'd3;
  localparam logic [2:0] REG_START_TO  = 3'd4;
  localparam logic [2:0] REG_CAL       = 3'd5;

  localparam logic [6:0]  DUTY_OFF       = 7'd100;
  localparam logic [12:0] VOLT_HIGH_DV   = 13'd2420;
  localparam logic [12:0] VOLT_LOW_DV    = 13'd1980;
  localparam logic [16:0] UNDERCUR_MA    = 17'd2000;
  localparam logic [2:0]  PAUSE_LIMIT    = 3'd4;
  localparam logic [2:0]  PAUSE_MAX      = 3'd7;

  typedef struct packed {
    acps_cmd_e   command;
    logic [2:0]  pilot_level;
    logic        stop_button;
    logic [12:0] voltage_dv;
    logic [16:0] current_ma;
    logic        meter_fault;
  } acps_item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        gun_present;
    logic        scram_active;
    logic        over_voltage;
    logic        under_voltage;
    logic [3:0]  stop_cause;
    logic [6:0]  pwm_duty;
    logic        contactor_on;
    logic        command_failed;
  } acps_result_t;

  typedef struct packed {
    logic [6:0]  duty;
    logic [15:0] oc_ticks;
    logic [15:0] uc_ticks;
    logic [15:0] susp_ticks;
    logic [15:0] start_ticks;
    logic [15:0] cal_ticks;
    logic [16:0] oc_limit;
  } acps_cfg_t;

  // Overcurrent limit in mA. The base is always a multiple of 100 mA, so it is
  // tracked in units of 100 mA: 6/duty-% from 10 % to 85 %, 25*(duty-64) up to 90 %
  // capped at 630. Above 20 A the margin is 10 %, which is then exact.
  function automatic logic [16:0] oc_limit(logic [6:0] duty);
    logic [9:0]  b100;
    logic [16:0] lim;
    b100 = '0;
    if (duty >= 7'd10 && duty <= 7'd85) begin
      b100 = 10'(duty) * 10'd6;
    end else if (duty >= 7'd86 && duty <= 7'd90) begin
      b100 = (10'(duty) - 10'd64) * 10'd25;
      if (b100 > 10'd630) begin
        b100 = 10'd630;
      end
    end
    if (b100 <= 10'd200) begin
      lim = 17'(b100) * 17'd100 + 17'd2000;
    end else begin
      lim = 17'(b100) * 17'd110;
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

FILE: design/acps_cfg_regs.sv
`default_nettype none

module acps_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [acps_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output acps_pkg::acps_cfg_t                cfg_o
);

  logic [6:0]  duty_q;
  logic [15:0] oc_ticks_q, uc_ticks_q, susp_ticks_q, start_ticks_q, cal_ticks_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q        <= 7'd53;
      oc_ticks_q    <= 16'd333;
      uc_ticks_q    <= 16'd8000;
      susp_ticks_q  <= 16'd4000;
      start_ticks_q <= 16'd2000;
      cal_ticks_q   <= 16'd133;
    end else if (wr_en) begin
      case (reg_idx)
        acps_pkg::REG_DUTY:     duty_q        <= pwdata[6:0];
        acps_pkg::REG_OC_TICKS: oc_ticks_q    <= pwdata[15:0];
        acps_pkg::REG_UC_TICKS: uc_ticks_q    <= pwdata[15:0];
        acps_pkg::REG_SUSP:     susp_ticks_q  <= pwdata[15:0];
        acps_pkg::REG_START_TO: start_ticks_q <= pwdata[15:0];
        acps_pkg::REG_CAL:      cal_ticks_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      acps_pkg::REG_DUTY:     prdata = {25'd0, duty_q};
      acps_pkg::REG_OC_TICKS: prdata = {16'd0, oc_ticks_q};
      acps_pkg::REG_UC_TICKS: prdata = {16'd0, uc_ticks_q};
      acps_pkg::REG_SUSP:     prdata = {16'd0, susp_ticks_q};
      acps_pkg::REG_START_TO: prdata = {16'd0, start_ticks_q};
      acps_pkg::REG_CAL:      prdata = {16'd0, cal_ticks_q};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.duty        = duty_q;
    cfg_o.oc_ticks    = oc_ticks_q;
    cfg_o.uc_ticks    = uc_ticks_q;
    cfg_o.susp_ticks  = susp_ticks_q;
    cfg_o.start_ticks = start_ticks_q;
    cfg_o.cal_ticks   = cal_ticks_q;
    cfg_o.oc_limit    = acps_pkg::oc_limit(duty_q);
  end

endmodule

`default_nettype wire

FILE: design/acps_core.sv
`default_nettype none

module acps_core #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   adv_i,
  input  acps_pkg::acps_item_t        item_i,
  input  acps_pkg::acps_cfg_t         cfg_i,
  output acps_pkg::acps_result_t      res_o
);

  localparam int unsigned TW = TIMER_WIDTH;
  localparam int unsigned CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  acps_pkg::acps_phase_e phase_q, phase_d;
  logic [3:0]    cause_q, cause_d;
  logic [2:0]    pcnt_q, pcnt_d;
  logic          paused_q, paused_d;
  logic          cal_act_q, cal_act_d;
  logic          lvs_q, lvs_d;
  logic [TW-1:0] oc_t_q, oc_t_d, uc_t_q, uc_t_d, su_t_q, su_t_d;
  logic [TW-1:0] st_t_q, st_t_d, ca_t_q, ca_t_d;
  logic [6:0]    duty_q, duty_d;
  logic          cont_q, cont_d;

  logic scram, over_v, under_v, failed, calib, was_chg;
  logic pilot_stop;

  function automatic logic ge_ticks(logic [TW-1:0] t, logic [15:0] k);
    return CW'(t) >= CW'(k);
  endfunction

  function automatic logic [TW-1:0] bump(logic [TW-1:0] t);
    return (t == {TW{1'b1}}) ? t : t + TW'(1);
  endfunction

  assign pilot_stop = (item_i.pilot_level == acps_pkg::PILOT_12V) ||
                      (item_i.pilot_level == acps_pkg::PILOT_0V);

  always_comb begin
    phase_d   = phase_q;
    cause_d   = cause_q;
    pcnt_d    = pcnt_q;
    paused_d  = paused_q;
    cal_act_d = cal_act_q;
    lvs_d     = lvs_q;
    oc_t_d    = oc_t_q;
    uc_t_d    = uc_t_q;
    su_t_d    = su_t_q;
    st_t_d    = st_t_q;
    ca_t_d    = ca_t_q;
    duty_d    = duty_q;
    cont_d    = cont_q;
    scram     = 1'b0;
    over_v    = 1'b0;
    under_v   = 1'b0;
    failed    = 1'b0;
    calib     = 1'b0;
    was_chg   = 1'b0;

    unique case (item_i.command)
      acps_pkg::CMD_START: begin
        if (phase_q != acps_pkg::PH_IDLE) begin
          failed = 1'b1;
        end else begin
          cause_d = acps_pkg::CAUSE_NORMAL;
          if (item_i.stop_button ||
              !(item_i.pilot_level == acps_pkg::PILOT_9V ||
                item_i.pilot_level == acps_pkg::PILOT_6V)) begin
            failed = 1'b1;
          end else begin
            duty_d = cfg_i.duty;
            if (item_i.pilot_level == acps_pkg::PILOT_6V) begin
              cont_d   = 1'b1;
              uc_t_d   = '0;
              paused_d = 1'b0;
              phase_d  = acps_pkg::PH_CHARGE;
            end else begin
              st_t_d  = '0;
              phase_d = acps_pkg::PH_WAIT;
            end
          end
        end
      end
      acps_pkg::CMD_STOP: begin
        duty_d   = acps_pkg::DUTY_OFF;
        cont_d   = 1'b0;
        phase_d  = acps_pkg::PH_IDLE;
        cause_d  = acps_pkg::CAUSE_NORMAL;
        paused_d = 1'b0;
        pcnt_d   = '0;
        uc_t_d   = '0;
      end
      acps_pkg::CMD_CALIBRATE: begin
        cal_act_d = 1'b1;
        ca_t_d    = '0;
      end
      acps_pkg::CMD_TICK: begin
        if (cal_act_q) begin
          if (ge_ticks(ca_t_q, cfg_i.cal_ticks)) begin
            cal_act_d = 1'b0;
          end else begin
            calib  = 1'b1;
            ca_t_d = bump(ca_t_q);
          end
        end
        if (phase_q == acps_pkg::PH_WAIT) begin
          // start handshake only
          if (item_i.pilot_level == acps_pkg::PILOT_6V) begin
            cont_d   = 1'b1;
            uc_t_d   = '0;
            paused_d = 1'b0;
            phase_d  = acps_pkg::PH_CHARGE;
          end else begin
            st_t_d = bump(st_t_q);
            if (ge_ticks(st_t_d, cfg_i.start_ticks) || pilot_stop) begin
              cause_d = acps_pkg::CAUSE_PILOT;
              duty_d  = acps_pkg::DUTY_OFF;
              phase_d = acps_pkg::PH_IDLE;
              failed  = 1'b1;
            end
          end
        end else begin
          was_chg = (phase_q == acps_pkg::PH_CHARGE);
          if (item_i.stop_button) begin
            scram   = 1'b1;
            cause_d = acps_pkg::CAUSE_SCRAM;
            phase_d = acps_pkg::PH_IDLE;
          end
          if (!calib) begin
            if (item_i.voltage_dv > acps_pkg::VOLT_HIGH_DV) begin
              over_v  = 1'b1;
              cause_d = acps_pkg::CAUSE_OVERVOLT;
              phase_d = acps_pkg::PH_IDLE;
            end
            if (item_i.voltage_dv < acps_pkg::VOLT_LOW_DV) begin
              if (lvs_q) begin
                under_v = 1'b1;
                cause_d = acps_pkg::CAUSE_UNDERVOLT;
                phase_d = acps_pkg::PH_IDLE;
              end
              lvs_d = 1'b1;
            end else begin
              lvs_d = 1'b0;
            end
          end else begin
            lvs_d = 1'b0;
          end
          if (item_i.current_ma > cfg_i.oc_limit) begin
            if (ge_ticks(oc_t_q, cfg_i.oc_ticks)) begin
              cause_d = acps_pkg::CAUSE_OVERCUR;
              if (!calib) begin
                phase_d = acps_pkg::PH_IDLE;
              end
            end
            oc_t_d = bump(oc_t_q);
          end else begin
            oc_t_d = '0;
          end
          if (phase_d == acps_pkg::PH_CHARGE) begin
            if (item_i.current_ma < acps_pkg::UNDERCUR_MA) begin
              if (ge_ticks(uc_t_q, cfg_i.uc_ticks)) begin
                uc_t_d  = '0;
                cause_d = acps_pkg::CAUSE_UNDERCUR;
                if (!calib) begin
                  phase_d = acps_pkg::PH_IDLE;
                end
              end else begin
                uc_t_d = bump(uc_t_q);
              end
            end else begin
              uc_t_d = '0;
            end
            if (item_i.meter_fault) begin
              cause_d = acps_pkg::CAUSE_METER;
              phase_d = acps_pkg::PH_IDLE;
            end
            if (pilot_stop) begin
              duty_d  = acps_pkg::DUTY_OFF;
              cont_d  = 1'b0;
              cause_d = acps_pkg::CAUSE_PILOT;
              phase_d = acps_pkg::PH_IDLE;
            end else if (item_i.pilot_level == acps_pkg::PILOT_6V) begin
              if (paused_q) begin
                paused_d = 1'b0;
                uc_t_d   = '0;
                cont_d   = 1'b1;
              end
            end else if (item_i.pilot_level == acps_pkg::PILOT_9V) begin
              uc_t_d = '0;
              if (!paused_q) begin
                cont_d   = 1'b0;
                paused_d = 1'b1;
                if (pcnt_q < acps_pkg::PAUSE_MAX) begin
                  pcnt_d = pcnt_q + 3'd1;
                end
                if (pcnt_d >= acps_pkg::PAUSE_LIMIT) begin
                  cause_d = acps_pkg::CAUSE_PAUSES;
                  phase_d = acps_pkg::PH_IDLE;
                end
                su_t_d = '0;
              end else begin
                su_t_d = bump(su_t_q);
                if (ge_ticks(su_t_d, cfg_i.susp_ticks)) begin
                  su_t_d  = '0;
                  cause_d = acps_pkg::CAUSE_SUSPEND;
                  phase_d = acps_pkg::PH_IDLE;
                end
              end
            end
          end
          if (was_chg && phase_d == acps_pkg::PH_IDLE) begin
            duty_d   = acps_pkg::DUTY_OFF;
            cont_d   = 1'b0;
            pcnt_d   = '0;
            paused_d = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= acps_pkg::PH_IDLE;
      cause_q   <= acps_pkg::CAUSE_NORMAL;
      pcnt_q    <= '0;
      paused_q  <= 1'b0;
      cal_act_q <= 1'b0;
      lvs_q     <= 1'b0;
      oc_t_q    <= '0;
      uc_t_q    <= '0;
      su_t_q    <= '0;
      st_t_q    <= '0;
      ca_t_q    <= '0;
      duty_q    <= acps_pkg::DUTY_OFF;
      cont_q    <= 1'b0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      cause_q   <= cause_d;
      pcnt_q    <= pcnt_d;
      paused_q  <= paused_d;
      cal_act_q <= cal_act_d;
      lvs_q     <= lvs_d;
      oc_t_q    <= oc_t_d;
      uc_t_q    <= uc_t_d;
      su_t_q    <= su_t_d;
      st_t_q    <= st_t_d;
      ca_t_q    <= ca_t_d;
      duty_q    <= duty_d;
      cont_q    <= cont_d;
    end
  end

  always_comb begin
    res_o.phase          = phase_d;
    res_o.gun_present    = (item_i.pilot_level == acps_pkg::PILOT_9V) ||
                           (item_i.pilot_level == acps_pkg::PILOT_6V);
    res_o.scram_active   = scram;
    res_o.over_voltage   = over_v;
    res_o.under_voltage  = under_v;
    res_o.stop_cause     = cause_d;
    res_o.pwm_duty       = duty_d;
    res_o.contactor_on   = cont_d;
    res_o.command_failed = failed;
  end

endmodule

`default_nettype wire

FILE: design/ac_charger_pilot_supervisor.sv
// AC charging-point control pilot supervisor.
// Input channel (in_valid_i/in_ready_o): one command per transaction -- a
// supervision tick with pilot level, stop button, voltage, current and meter
// status, or a start, stop or calibrate request.
// Output channel (out_valid_o/out_ready_i): exactly one result transaction per
// command: charge phase, pilot duty, contactor, fault flags and stop cause.
// The accepting edge loads the input register; the command then moves into
// the result register as soon as that is empty or being drained.
// Throughput: one command per cycle while out_ready_i stays high.
// A pending result does not block input: the input register keeps taking
// transactions as long as the result register drains or is empty; when the
// receiver stalls, one command waits in the input register and in_ready_o
// drops only once both stages are full.
// Configuration: APB registers at byte address 4*index (duty, overcurrent,
// undercurrent, suspend, start timeout, calibration window); write only while
// idle. Reset returns the configuration, timers and charge state to their
// reset values: phase idle, duty 100 %, contactor open, both stages empty.
`default_nettype none

`include "assert_macros.svh"

module ac_charger_pilot_supervisor #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [acps_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   command_i,
  input  wire logic [2:0]                   pilot_level_i,
  input  wire logic                         stop_button_i,
  input  wire logic [12:0]                  voltage_dv_i,
  input  wire logic [16:0]                  current_ma_i,
  input  wire logic                         meter_fault_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        phase_o,
  output logic                              gun_present_o,
  output logic                              scram_active_o,
  output logic                              over_voltage_o,
  output logic                              under_voltage_o,
  output logic [3:0]                        stop_cause_o,
  output logic [6:0]                        pwm_duty_o,
  output logic                              contactor_on_o,
  output logic                              command_failed_o
);

  acps_pkg::acps_cfg_t    cfg;
  acps_pkg::acps_item_t   item_q;
  acps_pkg::acps_result_t res_d, res_q;
  logic                   in_vld_q, out_vld_q, adv;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  acps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  acps_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.command     <= acps_pkg::acps_cmd_e'(command_i);
      item_q.pilot_level <= pilot_level_i;
      item_q.stop_button <= stop_button_i;
      item_q.voltage_dv  <= voltage_dv_i;
      item_q.current_ma  <= current_ma_i;
      item_q.meter_fault <= meter_fault_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign phase_o          = res_q.phase;
  assign gun_present_o    = res_q.gun_present;
  assign scram_active_o   = res_q.scram_active;
  assign over_voltage_o   = res_q.over_voltage;
  assign under_voltage_o  = res_q.under_voltage;
  assign stop_cause_o     = res_q.stop_cause;
  assign pwm_duty_o       = res_q.pwm_duty;
  assign contactor_on_o   = res_q.contactor_on;
  assign command_failed_o = res_q.command_failed;

  `ACPS_ASSERT(a_contactor_needs_charge, clk_i, rst_ni, out_valid_o && contactor_on_o |-> phase_o == acps_pkg::PH_CHARGE, "contactor closed outside charging")
  `ACPS_ASSERT(a_idle_duty_off, clk_i, rst_ni, out_valid_o && phase_o == acps_pkg::PH_IDLE |-> pwm_duty_o == acps_pkg::DUTY_OFF, "idle with pilot PWM running")
  `ACPS_ASSERT(a_input_moves_on, clk_i, rst_ni, in_vld_q && !out_vld_q |=> out_vld_q, "input stage did not advance into empty result stage")
  `ACPS_ASSERT(a_accept_loads_stage, clk_i, rst_ni, in_valid_i && in_ready_o |=> in_vld_q, "accepted transaction not held in input stage")
  `ACPS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o && in_ready_o, "pipeline not empty in reset")

endmodule

`default_nettype wire
